/* rtl/box_blur_3x3_edge_average_core_defines.svh */
// assertion macros for the 3x3 box blur core
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BB3_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB3_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/bb3_pkg.sv */
// shared types, constants and the rounding mean for the 3x3 box blur
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CFG_W = 11;
  localparam int EW = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;

  // register file
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_IMAGE_WIDTH = '0;

  // result queue, counted in result pairs
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  // per channel sum of up to nine pixels and tap count
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;

  // reciprocals scaled by 2^16, exact for all quotients reached here
  localparam int RECIP_W = 15;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP5 = 15'd13108;
  localparam logic [RECIP_W-1:0] RECIP7 = 15'd9363;
  localparam logic [RECIP_W-1:0] RECIP9 = 15'd7282;

  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic   valid;
    pixel_t px;
  } tap_t;

  typedef struct packed {
    tap_t two_above;
    tap_t above;
  } line_word_t;

  // rows top to bottom, columns left to right: index is row*3+col
  typedef tap_t [8:0] window_t;

  typedef struct packed {
    logic   flush;
    logic   first_col;
    logic   last_col;
    col_t   col;
    pixel_t px;
  } item_t;

  typedef struct packed {
    logic full;
    logic right;
    logic eoi;
  } emit_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
  } sums_t;

  typedef struct packed {
    pixel_t px;
    logic   eor;
    logic   eoi;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } pair_t;

  // (2*sum + n) / (2*n) with n of 0 taken as 1
  function automatic logic [7:0] mean8(input logic [SUM_W-1:0] sum,
                                       input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0]         nn;
    logic [SUM_W:0]           x;
    logic [SUM_W:0]           y;
    logic [2:0]               pre;
    logic [RECIP_W-1:0]       recip;
    logic                     use_mul;
    logic [SUM_W+RECIP_W:0]   prod;
    nn = (cnt == '0) ? CNT_W'(1) : cnt;
    x = {sum, 1'b0} + (SUM_W+1)'(nn);
    pre = 3'd1;
    recip = RECIP3;
    use_mul = 1'b0;
    case (nn)
      4'd1: pre = 3'd1;
      4'd2: pre = 3'd2;
      4'd3: begin pre = 3'd1; recip = RECIP3; use_mul = 1'b1; end
      4'd4: pre = 3'd3;
      4'd5: begin pre = 3'd1; recip = RECIP5; use_mul = 1'b1; end
      4'd6: begin pre = 3'd2; recip = RECIP3; use_mul = 1'b1; end
      4'd7: begin pre = 3'd1; recip = RECIP7; use_mul = 1'b1; end
      4'd8: pre = 3'd4;
      4'd9: begin pre = 3'd1; recip = RECIP9; use_mul = 1'b1; end
      default: pre = 3'd1;
    endcase
    y = x >> pre;
    prod = (SUM_W+RECIP_W+1)'(y) * (SUM_W+RECIP_W+1)'(recip);
    return use_mul ? prod[RECIP_SHIFT +: 8] : y[7:0];
  endfunction

endpackage

/* rtl/bb3_ram.sv */
// simple dual-port synchronous ram, read-first, registered read data
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 50,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bb3_window.sv */
// line buffer read-modify-write and 3x3 window update
`timescale 1ns / 1ps
module bb3_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  bb3_pkg::item_t      item,
  input  bb3_pkg::line_word_t ram_q,
  output logic                wr_en,
  output bb3_pkg::col_t       wr_col,
  output bb3_pkg::line_word_t wr_word,
  output logic                emit_valid,
  output bb3_pkg::emit_t      emit,
  output bb3_pkg::window_t    window
);
  import bb3_pkg::*;

  localparam int W_TOP_RIGHT = 2;
  localparam int W_CENTER    = 4;
  localparam int W_MID_RIGHT = 5;
  localparam int W_BOT_RIGHT = 8;

  logic       fwd_valid;
  col_t       fwd_col;
  line_word_t fwd_word;
  line_word_t line;
  tap_t       new_tap;
  window_t    base;
  window_t    window_next;

  always_comb begin
    // if the previous request wrote this column, the ram read still has old data
    line = (fwd_valid && fwd_col == item.col) ? fwd_word : ram_q;
    new_tap.valid = !item.flush;
    new_tap.px = item.flush ? '0 : item.px;
    base = window;
    if (item.first_col) begin
      for (int i = 0; i < 9; i++) begin
        base[i].valid = 1'b0;
      end
    end
    window_next = base;
    for (int r = 0; r < 3; r++) begin
      window_next[r*3]     = base[r*3 + 1];
      window_next[r*3 + 1] = base[r*3 + 2];
    end
    window_next[W_TOP_RIGHT] = line.two_above;
    window_next[W_MID_RIGHT] = line.above;
    window_next[W_BOT_RIGHT] = new_tap;
  end

  assign wr_en = item_valid;
  assign wr_col = item.col;
  assign wr_word.two_above = line.above;
  assign wr_word.above = new_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      emit_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      emit_valid <= item_valid;
      fwd_valid <= item_valid;
      if (item_valid) begin
        window <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_col <= item.col;
    fwd_word <= wr_word;
    emit.full <= !item.first_col && window_next[W_CENTER].valid;
    emit.right <= item.last_col && window_next[W_MID_RIGHT].valid;
    emit.eoi <= item.flush;
  end

endmodule

/* rtl/bb3_mean.sv */
// window sums, then rounded means packed as a result pair
`timescale 1ns / 1ps
module bb3_mean (
  input  logic             clk,
  input  logic             rst,
  input  logic             emit_valid,
  input  bb3_pkg::emit_t   emit,
  input  bb3_pkg::window_t window,
  output logic             push,
  output bb3_pkg::pair_t   pair
);
  import bb3_pkg::*;

  sums_t   right_sum;
  sums_t   full_sum;
  sums_t   right_q;
  sums_t   full_q;
  emit_t   emit_q;
  logic    busy;
  result_t res_full;
  result_t res_right;

  always_comb begin
    right_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 1; c < 3; c++) begin
        if (window[r*3 + c].valid) begin
          right_sum.red = right_sum.red + SUM_W'(window[r*3 + c].px.red);
          right_sum.green = right_sum.green + SUM_W'(window[r*3 + c].px.green);
          right_sum.blue = right_sum.blue + SUM_W'(window[r*3 + c].px.blue);
          right_sum.count = right_sum.count + CNT_W'(1);
        end
      end
    end
    full_sum = right_sum;
    for (int r = 0; r < 3; r++) begin
      if (window[r*3].valid) begin
        full_sum.red = full_sum.red + SUM_W'(window[r*3].px.red);
        full_sum.green = full_sum.green + SUM_W'(window[r*3].px.green);
        full_sum.blue = full_sum.blue + SUM_W'(window[r*3].px.blue);
        full_sum.count = full_sum.count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= emit_valid && (emit.full || emit.right);
    end
  end

  always_ff @(posedge clk) begin
    right_q <= right_sum;
    full_q <= full_sum;
    emit_q <= emit;
  end

  always_comb begin
    res_full.px.red = mean8(full_q.red, full_q.count);
    res_full.px.green = mean8(full_q.green, full_q.count);
    res_full.px.blue = mean8(full_q.blue, full_q.count);
    res_full.eor = 1'b0;
    res_full.eoi = 1'b0;
    res_right.px.red = mean8(right_q.red, right_q.count);
    res_right.px.green = mean8(right_q.green, right_q.count);
    res_right.px.blue = mean8(right_q.blue, right_q.count);
    res_right.eor = 1'b1;
    res_right.eoi = emit_q.eoi;
    // interior pixel first, the row's last pixel after it
    pair.first = emit_q.full ? res_full : res_right;
    pair.second = res_right;
    pair.two = emit_q.full && emit_q.right;
  end

  assign push = busy;

endmodule

/* rtl/bb3_out_fifo.sv */
// result queue of pairs, drained one result per handshake
`timescale 1ns / 1ps
module bb3_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  bb3_pkg::pair_t               wr_pair,
  input  logic                         out_ready,
  output logic                         out_valid,
  output bb3_pkg::result_t             head_res,
  output logic                         head_last,
  output logic [bb3_pkg::FCNT_W-1:0]   count
);
  import bb3_pkg::*;

  pair_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               sub;
  pair_t              head;
  logic               pop;
  logic               pop_entry;

  assign head = mem[rd_ptr];
  assign out_valid = (count != '0);
  assign head_res = sub ? head.second : head.first;
  assign head_last = !head.two || sub;
  assign pop = out_valid && out_ready;
  assign pop_entry = pop && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      sub <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop_entry) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        sub <= head.two && !sub;
      end
      count <= count + FCNT_W'(push) - FCNT_W'(pop_entry);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_pair;
    end
  end

endmodule

/* rtl/box_blur_3x3_edge_average_core.sv */
// 3x3 box blur core: line buffer ram, window, rounded means and result queue
// one request per cycle when in_ready is high; the request that releases a result
// trails its pixel by one row, and by one column for an interior result; row ends
// release up to two results, drained one per cycle when out_ready is high from an
// 8-pair queue; sync reset clears control, then a sweep zeroes all 1024 words of the
// line buffer ram (in_ready low during the sweep, register writes still taken)
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_average_core_defines.svh"
module box_blur_3x3_edge_average_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
  output logic [bb3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        last_in_run,
  output logic                        end_of_row,
  output logic                        end_of_image
);
  import bb3_pkg::*;

  logic [CFG_W-1:0]  image_width;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic              clearing;
  col_t              clr_addr;
  col_t              col_pos;
  logic              above0_valid;
  logic              s1_valid;
  item_t             s1_item;

  logic [EW-1:0]     w_eff;
  col_t              col_eff;
  logic              last_col;
  logic              drop;
  logic [FCNT_W:0]   occupancy;
  logic              accept;
  logic              take;

  line_word_t        ram_q;
  logic              win_we;
  col_t              win_col;
  line_word_t        win_word;
  logic              ram_we;
  col_t              ram_waddr;
  line_word_t        ram_wdata;

  logic              emit_valid;
  emit_t             emit;
  window_t           window;
  logic              fifo_push;
  pair_t             fifo_pair;
  result_t           head_res;
  logic              head_last;
  logic [FCNT_W-1:0] fifo_count;

  // register port
  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_idx == REG_IMAGE_WIDTH) ? DATA_W'(image_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
    end else if (cfg_wr && reg_idx == REG_IMAGE_WIDTH) begin
      image_width <= pwdata[CFG_W-1:0];
    end
  end

  // column bookkeeping for the incoming request
  always_comb begin
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
  end

  assign col_eff = (EW'(col_pos) >= w_eff) ? '0 : col_pos;
  assign last_col = (EW'(col_eff) == w_eff - EW'(1));
  // flush with no image row above column zero is swallowed
  assign drop = mode && (col_eff == '0) && !above0_valid;
  assign occupancy = (FCNT_W+1)'(fifo_count) + (FCNT_W+1)'(s1_valid)
                   + (FCNT_W+1)'(emit_valid) + (FCNT_W+1)'(fifo_push);
  assign in_ready = !clearing && (occupancy < (FCNT_W+1)'(FIFO_DEPTH));
  assign accept = in_valid && in_ready;
  assign take = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      col_pos <= '0;
      above0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + COL_W'(1);
        if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= take;
      if (take) begin
        col_pos <= last_col ? '0 : col_eff + COL_W'(1);
        if (col_eff == '0) begin
          above0_valid <= !mode;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.flush <= mode;
      s1_item.first_col <= (col_eff == '0);
      s1_item.last_col <= last_col;
      s1_item.col <= col_eff;
      s1_item.px.red <= in_red;
      s1_item.px.green <= in_green;
      s1_item.px.blue <= in_blue;
    end
  end

  // line buffer: both rows of one column in one word
  assign ram_we = clearing || win_we;
  assign ram_waddr = clearing ? clr_addr : win_col;
  assign ram_wdata = clearing ? '0 : win_word;

  bb3_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(line_word_t))
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col_eff),
    .rdata (ram_q)
  );

  bb3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item       (s1_item),
    .ram_q      (ram_q),
    .wr_en      (win_we),
    .wr_col     (win_col),
    .wr_word    (win_word),
    .emit_valid (emit_valid),
    .emit       (emit),
    .window     (window)
  );

  bb3_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit       (emit),
    .window     (window),
    .push       (fifo_push),
    .pair       (fifo_pair)
  );

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .wr_pair   (fifo_pair),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head_res  (head_res),
    .head_last (head_last),
    .count     (fifo_count)
  );

  assign out_red = head_res.px.red;
  assign out_green = head_res.px.green;
  assign out_blue = head_res.px.blue;
  assign last_in_run = head_last;
  assign end_of_row = head_res.eor;
  assign end_of_image = head_res.eoi;

  `BB3_ASSERT_NOW(a_fifo_room, clk, rst, fifo_push, fifo_count < FCNT_W'(FIFO_DEPTH), "result queue overflow")
  `BB3_ASSERT_NOW(a_clear_quiet, clk, rst, clearing, !s1_valid && !out_valid, "activity during ram sweep")
  `BB3_ASSERT_NOW(a_eoi_eor, clk, rst, out_valid && end_of_image, end_of_row, "image end not at row end")
  `BB3_ASSERT_NEXT(a_push_shows, clk, rst, fifo_push, out_valid, "pushed result not presented")

endmodule
